>>> rtl/dodq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dodq_pkg: shared types and constants of the deadline-ordered delay queue
// Holds the request and result structs, codes and the front/back command.
// ----------------------------------------------------------------------------
package dodq_pkg;

  localparam int unsigned TimeW     = 48;
  localparam int unsigned HandleW   = 16;
  localparam int unsigned QueueW    = 8;
  localparam int unsigned CountW    = 7;
  localparam int unsigned DepthDef  = 16;
  localparam int unsigned MaxRel    = 16;
  localparam logic [TimeW-1:0] MaxFutureReset = 48'd31536000000;

  typedef enum logic [1:0] {
    OP_SUBMIT = 2'd0,
    OP_TICK   = 2'd1,
    OP_STOP   = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    DISP_IMMEDIATE = 3'd0,
    DISP_RELEASED  = 3'd1,
    DISP_DROPPED   = 3'd2,
    DISP_REJECTED  = 3'd3,
    DISP_STOP      = 3'd4
  } disp_e;

  typedef struct packed {
    logic [1:0]         operation;
    logic [HandleW-1:0] message_handle;
    logic [QueueW-1:0]  queue_id;
    logic [TimeW-1:0]   deliver_at;
    logic               persistent;
    logic [TimeW-1:0]   now_ms;
  } req_t;

  typedef struct packed {
    logic [HandleW-1:0] out_handle;
    logic [QueueW-1:0]  out_queue;
    logic [2:0]         disposition;
    logic               deadline_cleared;
    logic [CountW-1:0]  discarded_count;
    logic               last;
  } res_t;

  // Work handed from the front to the back
  typedef enum logic [1:0] {
    CMD_EMIT   = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_TICK   = 2'd2,
    CMD_STOP   = 2'd3
  } cmd_e;

  typedef struct packed {
    cmd_e               cmd;
    logic [HandleW-1:0] handle;
    logic [QueueW-1:0]  queue;
    logic [TimeW-1:0]   time_val;
    logic [2:0]         disp;
    logic               cleared;
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RELEASE,
    ST_SHIFT
  } back_state_e;

endpackage
`default_nettype wire

>>> rtl/deadline_ordered_delay_queue_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// deadline_ordered_delay_queue_top: delayed message queue ordered by deadline
// Front classifier, one-command queue and sorted-store back end.
// ----------------------------------------------------------------------------
// A submit or stop has its result in the output register after it passes
// the front's command register; a stored submit gives no result. A tick
// walks the head of the sorted store and sends each due entry as a result,
// then shifts the store; the last released entry carries last. A command
// waits in the front while the output register holds an unaccepted result.
// The store keeps Depth entries; a full store rejects further submits.
module deadline_ordered_delay_queue_top #(
  parameter int unsigned Depth = dodq_pkg::DepthDef
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  input  wire dodq_pkg::req_t             in_data_i,
  output logic                            in_stall_o,
  output logic                            out_valid_o,
  output dodq_pkg::res_t                  out_data_o,
  input  wire logic                       out_stall_i,
  input  wire logic                       cfg_valid_i,
  input  wire logic [dodq_pkg::TimeW-1:0] cfg_data_i,
  output logic                            cfg_ready_o
);

  logic [dodq_pkg::TimeW-1:0] max_future_q;
  logic                       cmd_valid, cmd_take;
  dodq_pkg::cmd_t             cmd;

  // Hold the bound register
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_future_q <= dodq_pkg::MaxFutureReset;
    end else if (cfg_valid_i) begin
      max_future_q <= cfg_data_i;
    end
  end

  dodq_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .max_future_i (max_future_q),
    .req_valid_i  (in_valid_i),
    .req_i        (in_data_i),
    .req_stall_o  (in_stall_o),
    .cmd_valid_o  (cmd_valid),
    .cmd_o        (cmd),
    .cmd_take_i   (cmd_take)
  );

  dodq_back #(.Depth(Depth)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_take_o  (cmd_take),
    .res_valid_o (out_valid_o),
    .res_o       (out_data_o),
    .res_stall_i (out_stall_i)
  );

  // A stop report never counts more than the store holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.disposition == dodq_pkg::DISP_STOP |->
      out_data_o.discarded_count <= dodq_pkg::CountW'(Depth))
    else $error("stop count exceeds depth");

  // Only stop reports carry a count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.disposition != dodq_pkg::DISP_STOP |->
      out_data_o.discarded_count == '0)
    else $error("count on non-stop result");

  // Released entries are never marked cleared
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.disposition == dodq_pkg::DISP_RELEASED |->
      !out_data_o.deadline_cleared)
    else $error("released entry marked cleared");

endmodule
`default_nettype wire

>>> rtl/dodq_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dodq_front: request classifier
// Compares the deadline against now and the bound, tracks the stop flag and
// turns each submit, tick or stop request into a command for the back end.
// ----------------------------------------------------------------------------
module dodq_front (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic [dodq_pkg::TimeW-1:0] max_future_i,
  input  wire logic               req_valid_i,
  input  wire dodq_pkg::req_t     req_i,
  output logic                    req_stall_o,
  output logic                    cmd_valid_o,
  output dodq_pkg::cmd_t          cmd_o,
  input  wire logic               cmd_take_i
);

  logic           stopped_q, stopped_d;
  logic           full_q, full_d;
  dodq_pkg::cmd_t cmd_q, cmd_d;
  logic           fire;
  logic           later, over, immediate;
  logic [dodq_pkg::TimeW-1:0] span;

  // One-entry queue toward the back end
  assign req_stall_o = full_q && !cmd_take_i;
  assign fire        = req_valid_i && !req_stall_o;
  assign cmd_valid_o = full_q;
  assign cmd_o       = cmd_q;

  // Classify the request
  always_comb begin
    later     = req_i.deliver_at > req_i.now_ms;
    span      = req_i.deliver_at - req_i.now_ms;
    over      = later && (span > max_future_i);
    immediate = over || !later;
    cmd_d            = cmd_q;
    cmd_d.handle     = req_i.message_handle;
    cmd_d.queue      = req_i.queue_id;
    cmd_d.time_val   = req_i.now_ms;
    cmd_d.cleared    = 1'b0;
    cmd_d.disp       = dodq_pkg::DISP_IMMEDIATE;
    cmd_d.cmd        = dodq_pkg::CMD_EMIT;
    stopped_d        = stopped_q;
    full_d           = full_q && !cmd_take_i;
    if (fire) begin
      unique case (dodq_pkg::op_e'(req_i.operation))
        dodq_pkg::OP_SUBMIT: begin
          full_d = 1'b1;
          if (immediate) begin
            cmd_d.cleared = over;
          end else if (stopped_q) begin
            cmd_d.disp = req_i.persistent ? dodq_pkg::DISP_DROPPED
                                          : dodq_pkg::DISP_IMMEDIATE;
          end else begin
            cmd_d.cmd      = dodq_pkg::CMD_INSERT;
            cmd_d.time_val = req_i.deliver_at;
          end
        end
        dodq_pkg::OP_TICK: begin
          full_d    = 1'b1;
          cmd_d.cmd = dodq_pkg::CMD_TICK;
        end
        dodq_pkg::OP_STOP: begin
          full_d    = 1'b1;
          cmd_d.cmd = dodq_pkg::CMD_STOP;
          stopped_d = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stopped_q <= 1'b0;
      full_q    <= 1'b0;
    end else begin
      stopped_q <= stopped_d;
      full_q    <= full_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      cmd_q <= cmd_d;
    end
  end

endmodule
`default_nettype wire

>>> rtl/dodq_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dodq_back: ordered store and result sequencer
// Keeps entries sorted by deadline as a shift array, inserts, releases due
// entries from the head and discards everything on stop.
// ----------------------------------------------------------------------------
module dodq_back #(
  parameter int unsigned Depth = dodq_pkg::DepthDef
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           cmd_valid_i,
  input  wire dodq_pkg::cmd_t cmd_i,
  output logic                cmd_take_o,
  output logic                res_valid_o,
  output dodq_pkg::res_t      res_o,
  input  wire logic           res_stall_i
);

  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam int unsigned RelW = $clog2(dodq_pkg::MaxRel + 1);

  logic [dodq_pkg::TimeW-1:0]   dl_q  [Depth];
  logic [dodq_pkg::HandleW-1:0] hd_q  [Depth];
  logic [dodq_pkg::QueueW-1:0]  qu_q  [Depth];
  logic [CntW-1:0]              cnt_q, cnt_d;
  logic [RelW-1:0]              rel_q, rel_d;
  dodq_pkg::back_state_e        state_q, state_d;
  logic [dodq_pkg::TimeW-1:0]   now_q;
  logic                         out_full_q, out_full_d;
  dodq_pkg::res_t               res_q, res_d;
  logic                         out_free;
  logic                         head_due, more_due;
  logic [Depth-1:0]             gt;
  logic                         do_insert, do_shift;

  assign out_free    = !out_full_q || !res_stall_i;
  assign res_valid_o = out_full_q;
  assign res_o       = res_q;

  // Head is due while entries remain and the release limit is not hit
  assign head_due = (cnt_q != '0) && (dl_q[0] <= now_q)
                    && (rel_q < RelW'(dodq_pkg::MaxRel));
  // A release after the current one would also be due
  assign more_due = (cnt_q > CntW'(1)) && (dl_q[1] <= now_q)
                    && (rel_q + RelW'(1) < RelW'(dodq_pkg::MaxRel));

  // Entries that must move up on insert: strictly later deadline
  always_comb begin
    for (int i = 0; i < Depth; i++) begin
      gt[i] = (CntW'(i) < cnt_q) && (dl_q[i] > cmd_i.time_val);
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      dodq_pkg::ST_IDLE: begin
        if (cmd_valid_i && out_free && cmd_i.cmd == dodq_pkg::CMD_TICK) begin
          state_d = dodq_pkg::ST_SCAN;
        end
      end
      dodq_pkg::ST_SCAN: begin
        if (head_due) begin
          if (out_free) state_d = dodq_pkg::ST_SHIFT;
        end else begin
          state_d = dodq_pkg::ST_IDLE;
        end
      end
      dodq_pkg::ST_SHIFT:   state_d = dodq_pkg::ST_SCAN;
      dodq_pkg::ST_RELEASE: state_d = dodq_pkg::ST_IDLE;
      default:              state_d = dodq_pkg::ST_IDLE;
    endcase
  end

  // Outputs and counters; take a command only while the result slot is free
  always_comb begin
    cmd_take_o = 1'b0;
    out_full_d = out_full_q && res_stall_i;
    res_d      = res_q;
    cnt_d      = cnt_q;
    rel_d      = rel_q;
    do_insert  = 1'b0;
    do_shift   = 1'b0;
    unique case (state_q)
      dodq_pkg::ST_IDLE: begin
        if (cmd_valid_i && out_free) begin
          res_d.out_handle       = cmd_i.handle;
          res_d.out_queue        = cmd_i.queue;
          res_d.disposition      = cmd_i.disp;
          res_d.deadline_cleared = cmd_i.cleared;
          res_d.discarded_count  = '0;
          res_d.last             = 1'b1;
          unique case (cmd_i.cmd)
            dodq_pkg::CMD_EMIT: begin
              if (out_free) begin
                cmd_take_o = 1'b1;
                out_full_d = 1'b1;
              end
            end
            dodq_pkg::CMD_INSERT: begin
              if (cnt_q >= CntW'(Depth)) begin
                res_d.disposition = dodq_pkg::DISP_REJECTED;
                if (out_free) begin
                  cmd_take_o = 1'b1;
                  out_full_d = 1'b1;
                end
              end else begin
                cmd_take_o = 1'b1;
                do_insert  = 1'b1;
                cnt_d      = cnt_q + CntW'(1);
              end
            end
            dodq_pkg::CMD_TICK: begin
              cmd_take_o = 1'b1;
              rel_d      = '0;
            end
            dodq_pkg::CMD_STOP: begin
              res_d.out_handle       = '0;
              res_d.out_queue        = '0;
              res_d.disposition      = dodq_pkg::DISP_STOP;
              res_d.deadline_cleared = 1'b0;
              res_d.discarded_count  = dodq_pkg::CountW'(cnt_q);
              if (out_free) begin
                cmd_take_o = 1'b1;
                out_full_d = 1'b1;
                cnt_d      = '0;
              end
            end
            default: ;
          endcase
        end
      end
      dodq_pkg::ST_SCAN: begin
        if (head_due && out_free) begin
          res_d.out_handle       = hd_q[0];
          res_d.out_queue        = qu_q[0];
          res_d.disposition      = dodq_pkg::DISP_RELEASED;
          res_d.deadline_cleared = 1'b0;
          res_d.discarded_count  = '0;
          res_d.last             = !more_due;
          out_full_d             = 1'b1;
        end
      end
      dodq_pkg::ST_SHIFT: begin
        do_shift = 1'b1;
        cnt_d    = cnt_q - CntW'(1);
        rel_d    = rel_q + RelW'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= dodq_pkg::ST_IDLE;
      cnt_q      <= '0;
      rel_q      <= '0;
      out_full_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      rel_q      <= rel_d;
      out_full_q <= out_full_d;
    end
  end

  // Payload: result register, tick time, sorted store
  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (state_q == dodq_pkg::ST_IDLE && cmd_valid_i && out_free &&
        cmd_i.cmd == dodq_pkg::CMD_TICK) begin
      now_q <= cmd_i.time_val;
    end
    for (int i = 0; i < Depth; i++) begin
      if (do_shift) begin
        if (i + 1 < Depth) begin
          dl_q[i] <= dl_q[(i + 1) % Depth];
          hd_q[i] <= hd_q[(i + 1) % Depth];
          qu_q[i] <= qu_q[(i + 1) % Depth];
        end
      end else if (do_insert) begin
        if (gt[i]) begin
          if (i + 1 < Depth) begin
            dl_q[(i + 1) % Depth] <= dl_q[i];
            hd_q[(i + 1) % Depth] <= hd_q[i];
            qu_q[(i + 1) % Depth] <= qu_q[i];
          end
        end
        // Slot where the new entry lands: first later entry or end of list
        if ((CntW'(i) <= cnt_q) &&
            ((i == 0) ? 1'b1 : !gt[(i + Depth - 1) % Depth]) &&
            ((CntW'(i) == cnt_q) || gt[i])) begin
          dl_q[i] <= cmd_i.time_val;
          hd_q[i] <= cmd_i.handle;
          qu_q[i] <= cmd_i.queue;
        end
      end
    end
  end

endmodule
`default_nettype wire
